### sv/cubic_bezier_path_evaluator_top_assert.svh
// Assertion macros for the Bezier path evaluator.
// Included by cubic_bezier_path_evaluator_top.sv; defines empty bodies when SYNTH is set.
`ifndef CUBIC_BEZIER_PATH_EVALUATOR_TOP_ASSERT_SVH
`define CUBIC_BEZIER_PATH_EVALUATOR_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted
`define CBPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbpe: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted
`define CBPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbpe: next-cycle check failed");
`else
`define CBPE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CBPE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/cbpe_pkg.sv
// Shared constants and types of the cubic Bezier path evaluator.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package cbpe_pkg;

	// default configuration
	localparam int SEGMENTS_DEF        = 8;
	localparam int COORD_BITS_DEF      = 24;
	localparam int PHASE_FRAC_BITS_DEF = 16;

	// fixed field widths
	localparam int PHASE_BITS = 32;
	localparam int INDEX_BITS = 5;

	// floor(i / 3) = (i * 11) >> 5 holds for every 5-bit i
	localparam int DIV3_MUL   = 11;
	localparam int DIV3_SHIFT = 5;
	localparam int QUOT3_BITS = 4;
	localparam int DIV3_PROD_BITS = INDEX_BITS + QUOT3_BITS;

	// beat function codes
	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

endpackage

`default_nettype wire

### sv/cbpe_if.sv
// Command and result channel interfaces of the Bezier path evaluator.
// Depends on cbpe_pkg for field widths and the function code type.
`default_nettype none

interface cbpe_cmd_if #(
	parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
) ();
	logic                                 valid;
	logic                                 ready;
	cbpe_pkg::func_t                      func;
	logic [cbpe_pkg::INDEX_BITS-1:0]      point_index;
	logic signed [COORD_BITS-1:0]         point_x;
	logic signed [COORD_BITS-1:0]         point_y;
	logic signed [COORD_BITS-1:0]         point_z;
	logic [cbpe_pkg::PHASE_BITS-1:0]      phase;

	modport source (
		output valid, func, point_index, point_x, point_y, point_z, phase,
		input  ready
	);
	modport sink (
		input  valid, func, point_index, point_x, point_y, point_z, phase,
		output ready
	);
endinterface

interface cbpe_res_if #(
	parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [COORD_BITS-1:0]   pos_x;
	logic signed [COORD_BITS-1:0]   pos_y;
	logic signed [COORD_BITS-1:0]   pos_z;
	logic signed [COORD_BITS+1:0]   vel_x;
	logic signed [COORD_BITS+1:0]   vel_y;
	logic signed [COORD_BITS+1:0]   vel_z;

	modport source (
		output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		output ready
	);
endinterface

`default_nettype wire

### sv/cubic_bezier_path_evaluator_top.sv
// Top level of the cubic Bezier path evaluator: point banks and evaluation pipeline.
// Depends on cbpe_pkg, cbpe_if.sv and cubic_bezier_path_evaluator_top_assert.svh.
//
//   channel | side   | beat carries
//   --------+--------+-----------------------------------------------------
//   cmd     | sink   | func, point_index, point_x/y/z, phase
//   res     | source | pos_x/y/z, vel_x/vel_y/vel_z (one per evaluate beat)
//
// One beat per cycle enters as long as res does not stall.
// The ten register stages are fully pipelined; each of the four point banks gives
// one read per cycle, so the four control points of a segment come in one access.
// Loads write the banks at stage 3 and are dropped there, keeping load/evaluate order.
// Reset clears only the stage valid bits; bank contents are unknown until loaded.
// A stall on res holds only the full stages; bubbles in front of it close up.
`default_nettype none

`include "cubic_bezier_path_evaluator_top_assert.svh"

module cubic_bezier_path_evaluator_top #(
	parameter int SEGMENTS        = cbpe_pkg::SEGMENTS_DEF,
	parameter int COORD_BITS      = cbpe_pkg::COORD_BITS_DEF,
	parameter int PHASE_FRAC_BITS = cbpe_pkg::PHASE_FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cbpe_cmd_if.sink   cmd,
	cbpe_res_if.source res
);

	localparam int CB  = COORD_BITS;
	localparam int PFB = PHASE_FRAC_BITS;
	localparam int AW  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int IW  = cbpe_pkg::PHASE_BITS - PFB;
	localparam int SW  = $clog2(2 * SEGMENTS);
	localparam int DW  = CB + 1;
	localparam int PW  = DW + PFB + 1;
	localparam int VW  = CB + 2;
	localparam int TW  = CB + 3;
	localparam int PTW = 3 * CB;

	// floor(2^IW / SEGMENTS): the quotient estimate is low by at most one
	localparam int RECIP = (1 << IW) / SEGMENTS;
	localparam logic [IW:0] RECIP_C = (IW+1)'(RECIP);
	localparam logic signed [PW-1:0] HALF = PW'(1) << (PFB - 1);
	localparam logic signed [VW-1:0] VMAX = signed'({1'b0, {(VW-1){1'b1}}});
	localparam logic signed [VW-1:0] VMIN = signed'({1'b1, {(VW-1){1'b0}}});

	typedef struct packed {
		logic b0;
		logic b1;
		logic b2;
		logic b3;
	} bank_we_t;

	// (b - a) * f as a signed product
	function automatic logic signed [PW-1:0] lerp_mul(
		input logic signed [CB-1:0] a,
		input logic signed [CB-1:0] b,
		input logic [PFB-1:0]       f
	);
		logic signed [DW-1:0] d;
		logic signed [PW-1:0] dw;
		logic signed [PW-1:0] fw;
		d  = DW'(b) - DW'(a);
		dw = PW'(d);
		fw = signed'({{(PW-PFB){1'b0}}, f});
		return dw * fw;
	endfunction

	// a + floor((prod + half) / 2^PFB), round half up
	function automatic logic signed [CB-1:0] lerp_add(
		input logic signed [CB-1:0] a,
		input logic signed [PW-1:0] prod
	);
		logic signed [PW-1:0]     rnd;
		logic signed [PW-PFB-1:0] sh;
		logic signed [PW-PFB-1:0] sum;
		rnd = prod + HALF;
		sh  = rnd[PW-1:PFB];
		sum = (PW-PFB)'(a) + sh;
		return sum[CB-1:0];
	endfunction

	// saturate 3*(r1-r0) to the velocity range
	function automatic logic signed [VW-1:0] vel_sat(input logic signed [TW-1:0] v);
		if (v[TW-1] != v[TW-2]) begin
			return v[TW-1] ? VMIN : VMAX;
		end
		return v[VW-1:0];
	endfunction

	// stage advance enables
	logic [10:1] adv;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	// stage 1..3 payload
	logic             eval_s1, eval_s2, eval_s3;
	logic [IW-1:0]    n_s1;
	logic [IW-1:0]    q_s1;
	logic [SW-1:0]    rem_s2;
	logic [AW-1:0]    seg_s3;
	logic [PFB-1:0]   f_s1, f_s2, f_s3, f_s4, f_s5, f_s6, f_s7, f_s8;
	logic [PTW-1:0]   pt_s1, pt_s2, pt_s3;
	bank_we_t         we_s1, we_s2, we_s3;
	logic [AW-1:0]    wa_s1, wa_s2, wa_s3;
	logic [AW-1:0]    wa3_s1, wa3_s2, wa3_s3;

	// point banks: bank k entry s holds point 3s+k of the path
	logic [PTW-1:0]   mem0 [SEGMENTS];
	logic [PTW-1:0]   mem1 [SEGMENTS];
	logic [PTW-1:0]   mem2 [SEGMENTS];
	logic [PTW-1:0]   mem3 [SEGMENTS];
	logic [PTW-1:0]   rd_s4 [4];

	// arithmetic stages
	logic signed [CB-1:0] p [4][3];
	logic signed [PW-1:0] prod1_s5 [3][3];
	logic signed [CB-1:0] a1_s5 [3][3];
	logic signed [CB-1:0] q_s6 [3][3];
	logic signed [PW-1:0] prod2_s7 [2][3];
	logic signed [CB-1:0] a2_s7 [2][3];
	logic signed [CB-1:0] r_s8 [2][3];
	logic signed [PW-1:0] prod3_s9 [3];
	logic signed [CB-1:0] a3_s9 [3];
	logic signed [TW-1:0] vel3_s9 [3];
	logic signed [CB-1:0] pos_s10 [3];
	logic signed [VW-1:0] vel_s10 [3];

	// input decode
	logic [IW-1:0]                        n_in;
	logic [2*IW:0]                        recip_prod;
	logic [cbpe_pkg::DIV3_PROD_BITS-1:0]  m3;
	logic [cbpe_pkg::QUOT3_BITS-1:0]      q3;
	logic [cbpe_pkg::INDEX_BITS-1:0]      rem3;
	logic [1:0]                           r3;
	bank_we_t                             we_in;
	logic [IW-1:0]                        rem_full;
	logic                                 bank_wr;

	// chain the advance enables back from the output register
	always_comb begin
		adv[10] = !v_s10 || res.ready;
		adv[9]  = !v_s9  || adv[10];
		adv[8]  = !v_s8  || adv[9];
		adv[7]  = !v_s7  || adv[8];
		adv[6]  = !v_s6  || adv[7];
		adv[5]  = !v_s5  || adv[6];
		adv[4]  = !v_s4  || adv[5];
		adv[3]  = !v_s3  || adv[4];
		adv[2]  = !v_s2  || adv[3];
		adv[1]  = !v_s1  || adv[2];
	end

	assign cmd.ready = adv[1];

	// split the phase and estimate its segment quotient; decode the load index
	always_comb begin
		n_in       = cmd.phase[cbpe_pkg::PHASE_BITS-1:PFB];
		recip_prod = {{(IW+1){1'b0}}, n_in} * {{IW{1'b0}}, RECIP_C};
		m3   = cbpe_pkg::DIV3_PROD_BITS'(cmd.point_index) *
		       cbpe_pkg::DIV3_PROD_BITS'(cbpe_pkg::DIV3_MUL);
		q3   = m3[cbpe_pkg::DIV3_PROD_BITS-1:cbpe_pkg::DIV3_SHIFT];
		rem3 = cmd.point_index - ({1'b0, q3} + {q3, 1'b0});
		r3   = rem3[1:0];
		we_in.b0 = (r3 == 2'd0) && (32'(q3) < SEGMENTS);
		we_in.b1 = (r3 == 2'd1) && (32'(q3) < SEGMENTS);
		we_in.b2 = (r3 == 2'd2) && (32'(q3) < SEGMENTS);
		we_in.b3 = (r3 == 2'd0) && (q3 != '0) && (32'(q3) <= SEGMENTS);
		rem_full = n_s1 - IW'(q_s1 * SEGMENTS);
	end

	// move valid bits; loads leave the pipeline at stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (adv[1])  v_s1  <= cmd.valid;
			if (adv[2])  v_s2  <= v_s1;
			if (adv[3])  v_s3  <= v_s2;
			if (adv[4])  v_s4  <= v_s3 && eval_s3;
			if (adv[5])  v_s5  <= v_s4;
			if (adv[6])  v_s6  <= v_s5;
			if (adv[7])  v_s7  <= v_s6;
			if (adv[8])  v_s8  <= v_s7;
			if (adv[9])  v_s9  <= v_s8;
			if (adv[10]) v_s10 <= v_s9;
		end
	end

	// stages 1 to 3: segment reduction, carry load data to the bank write stage
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			eval_s1 <= (cmd.func == cbpe_pkg::FUNC_EVAL);
			n_s1    <= n_in;
			q_s1    <= recip_prod[2*IW-1:IW];
			f_s1    <= cmd.phase[PFB-1:0];
			pt_s1   <= {cmd.point_z, cmd.point_y, cmd.point_x};
			we_s1   <= we_in;
			wa_s1   <= AW'(32'(q3));
			wa3_s1  <= AW'(32'(q3) - 32'd1);
		end
		if (adv[2]) begin
			eval_s2 <= eval_s1;
			rem_s2  <= rem_full[SW-1:0];
			f_s2    <= f_s1;
			pt_s2   <= pt_s1;
			we_s2   <= we_s1;
			wa_s2   <= wa_s1;
			wa3_s2  <= wa3_s1;
		end
		if (adv[3]) begin
			eval_s3 <= eval_s2;
			if (32'(rem_s2) >= SEGMENTS) begin
				seg_s3 <= AW'(32'(rem_s2) - SEGMENTS);
			end else begin
				seg_s3 <= AW'(32'(rem_s2));
			end
			f_s3    <= f_s2;
			pt_s3   <= pt_s2;
			we_s3   <= we_s2;
			wa_s3   <= wa_s2;
			wa3_s3  <= wa3_s2;
		end
	end

	assign bank_wr = v_s3 && !eval_s3 && adv[4];

	// point banks: a load writes as it leaves stage 3, an evaluate reads all four
	always_ff @(posedge clk) begin
		if (bank_wr) begin
			if (we_s3.b0) mem0[wa_s3]  <= pt_s3;
			if (we_s3.b1) mem1[wa_s3]  <= pt_s3;
			if (we_s3.b2) mem2[wa_s3]  <= pt_s3;
			if (we_s3.b3) mem3[wa3_s3] <= pt_s3;
		end
		if (adv[4]) begin
			rd_s4[0] <= mem0[seg_s3];
			rd_s4[1] <= mem1[seg_s3];
			rd_s4[2] <= mem2[seg_s3];
			rd_s4[3] <= mem3[seg_s3];
			f_s4     <= f_s3;
		end
	end

	// unpack the four points per axis
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int a = 0; a < 3; a++) begin
				p[k][a] = signed'(rd_s4[k][a*CB +: CB]);
			end
		end
	end

	// stages 5 to 10: three levels of de Casteljau, then position and velocity
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					prod1_s5[k][a] <= lerp_mul(p[k][a], p[k+1][a], f_s4);
					a1_s5[k][a]    <= p[k][a];
				end
			end
			f_s5 <= f_s4;
		end
		if (adv[6]) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					q_s6[k][a] <= lerp_add(a1_s5[k][a], prod1_s5[k][a]);
				end
			end
			f_s6 <= f_s5;
		end
		if (adv[7]) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 2; k++) begin
					prod2_s7[k][a] <= lerp_mul(q_s6[k][a], q_s6[k+1][a], f_s6);
					a2_s7[k][a]    <= q_s6[k][a];
				end
			end
			f_s7 <= f_s6;
		end
		if (adv[8]) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 2; k++) begin
					r_s8[k][a] <= lerp_add(a2_s7[k][a], prod2_s7[k][a]);
				end
			end
			f_s8 <= f_s7;
		end
		if (adv[9]) begin
			for (int a = 0; a < 3; a++) begin
				prod3_s9[a] <= lerp_mul(r_s8[0][a], r_s8[1][a], f_s8);
				a3_s9[a]    <= r_s8[0][a];
				vel3_s9[a]  <= (TW'(r_s8[1][a]) - TW'(r_s8[0][a])) +
				               ((TW'(r_s8[1][a]) - TW'(r_s8[0][a])) <<< 1);
			end
		end
		// position is a convex blend of in-range points and needs no clamp
		if (adv[10]) begin
			for (int a = 0; a < 3; a++) begin
				pos_s10[a] <= lerp_add(a3_s9[a], prod3_s9[a]);
				vel_s10[a] <= vel_sat(vel3_s9[a]);
			end
		end
	end

	// drive the result beat from the output register
	assign res.valid = v_s10;
	assign res.pos_x = pos_s10[0];
	assign res.pos_y = pos_s10[1];
	assign res.pos_z = pos_s10[2];
	assign res.vel_x = vel_s10[0];
	assign res.vel_y = vel_s10[1];
	assign res.vel_z = vel_s10[2];

	// quotient estimate leaves less than twice the segment count
	`CBPE_ASSERT_IMP(a_rem_range, clk, arst_n, v_s2 && eval_s2, 32'(rem_s2) < 2 * SEGMENTS)
	// an empty first stage always takes a beat
	`CBPE_ASSERT_IMP(a_bubble_ready, clk, arst_n, !v_s1, cmd.ready)
	// a load that writes the banks never reaches the arithmetic stages
	`CBPE_ASSERT_NXT(a_load_drop, clk, arst_n, bank_wr, !v_s4)

endmodule

`default_nettype wire

### test/cubic_bezier_path_evaluator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for cubic_bezier_path_evaluator_top: point loads and path evaluations.
// Depends on cbpe_pkg and the interfaces of cbpe_if.sv; predicts each untyped result.

module cubic_bezier_path_evaluator_top_tb;

	localparam int SEGS    = cbpe_pkg::SEGMENTS_DEF;
	localparam int COORD   = cbpe_pkg::COORD_BITS_DEF;
	localparam int FRAC    = cbpe_pkg::PHASE_FRAC_BITS_DEF;
	localparam int IDXW    = cbpe_pkg::INDEX_BITS;
	localparam int PHW     = cbpe_pkg::PHASE_BITS;
	localparam int VELW    = COORD + 2;
	localparam int NPTS    = 3 * SEGS + 1;
	localparam int LATENCY = 10;

	localparam int C_MAX = (1 << (COORD - 1)) - 1;
	localparam int C_MIN = -C_MAX - 1;
	localparam int V_MAX = (1 << (COORD + 1)) - 1;
	localparam int V_MIN = -V_MAX - 1;

	localparam int ITEMS_PER_MIX = 275;
	localparam int HOLD_AT       = 120;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_LIMIT   = 20000;

	typedef struct packed {
		cbpe_pkg::func_t               func;
		logic [IDXW-1:0]               idx;
		logic signed [COORD-1:0]       x;
		logic signed [COORD-1:0]       y;
		logic signed [COORD-1:0]       z;
		logic [PHW-1:0]                phase;
	} cmd_beat_t;

	typedef struct packed {
		logic signed [COORD-1:0]       px;
		logic signed [COORD-1:0]       py;
		logic signed [COORD-1:0]       pz;
		logic signed [VELW-1:0]        vx;
		logic signed [VELW-1:0]        vy;
		logic signed [VELW-1:0]        vz;
	} res_beat_t;

	typedef struct packed {
		cmd_beat_t beat;
		logic      typed;
		res_beat_t want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	cbpe_cmd_if #(.COORD_BITS(COORD)) cmd_ch ();
	cbpe_res_if #(.COORD_BITS(COORD)) res_ch ();

	cubic_bezier_path_evaluator_top #(
		.SEGMENTS       (SEGS),
		.COORD_BITS     (COORD),
		.PHASE_FRAC_BITS(FRAC)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	// bench-side copy of the point table and the results still to come
	logic signed [COORD-1:0] pts [NPTS][3];
	res_beat_t               pending_results[$];
	plan_row_t               plan[$];

	// tag riding along with each command beat: typed-in expectation or not
	logic      row_typed;
	res_beat_t row_want;

	int accepted_beats;
	int recv_stall;
	int send_idle;
	int errors;
	int loads_seen;
	int ignored_seen;
	int evals_seen;
	int results_seen;
	int sat_seen;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#(2_000_000);
		$display("[cubic_bezier_path_evaluator_top] ERROR");
		$finish;
	end

	// one de Casteljau step, rounding half up
	function automatic longint lerp_q(longint a, longint b, longint f);
		return a + (((b - a) * f + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
	endfunction

	function automatic longint clamp_q(longint v, int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// position and velocity of the path at one phase
	function automatic res_beat_t bezier_eval(logic [PHW-1:0] ph);
		res_beat_t   r;
		int unsigned seg;
		longint      f;
		longint      p[4];
		longint      q0, q1, q2, r0, r1;
		longint      pos[3];
		longint      vel[3];
		seg = (ph >> FRAC) % SEGS;
		f   = longint'(ph[FRAC-1:0]);
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 4; k++)
				p[k] = pts[3 * seg + k][a];
			q0 = lerp_q(p[0], p[1], f);
			q1 = lerp_q(p[1], p[2], f);
			q2 = lerp_q(p[2], p[3], f);
			r0 = lerp_q(q0, q1, f);
			r1 = lerp_q(q1, q2, f);
			pos[a] = clamp_q(lerp_q(r0, r1, f), COORD);
			vel[a] = clamp_q(3 * (r1 - r0), VELW);
		end
		r.px = COORD'(pos[0]);
		r.py = COORD'(pos[1]);
		r.pz = COORD'(pos[2]);
		r.vx = VELW'(vel[0]);
		r.vy = VELW'(vel[1]);
		r.vz = VELW'(vel[2]);
		return r;
	endfunction

	// coordinate mix: extremes, small values, full range
	function automatic logic signed [COORD-1:0] rand_coord();
		int m;
		m = $urandom_range(99);
		if (m < 5)
			return COORD'(C_MIN);
		if (m < 10)
			return COORD'(C_MAX);
		if (m < 55)
			return COORD'($urandom_range(8191) - 4096);
		return COORD'($urandom);
	endfunction

	function automatic cmd_beat_t rand_cmd();
		cmd_beat_t b;
		int        pick;
		pick    = $urandom_range(99);
		b.idx   = IDXW'($urandom);
		b.x     = rand_coord();
		b.y     = rand_coord();
		b.z     = rand_coord();
		b.phase = $urandom;
		if (pick < 5) begin
			b.func = cbpe_pkg::FUNC_LOAD;
			b.idx  = IDXW'($urandom_range(31, NPTS));
		end else if (pick < 35) begin
			b.func = cbpe_pkg::FUNC_LOAD;
			b.idx  = IDXW'($urandom_range(NPTS - 1, 0));
		end else begin
			b.func = cbpe_pkg::FUNC_EVAL;
		end
		return b;
	endfunction

	function automatic void put_load(int idx, int x, int y, int z);
		plan_row_t r;
		r.beat.func  = cbpe_pkg::FUNC_LOAD;
		r.beat.idx   = IDXW'(idx);
		r.beat.x     = COORD'(x);
		r.beat.y     = COORD'(y);
		r.beat.z     = COORD'(z);
		r.beat.phase = $urandom;
		r.typed      = 1'b0;
		r.want       = '0;
		plan.push_back(r);
	endfunction

	function automatic void put_eval(logic [PHW-1:0] ph, logic typed,
			int px, int py, int pz, int vx, int vy, int vz);
		plan_row_t r;
		r.beat.func  = cbpe_pkg::FUNC_EVAL;
		r.beat.idx   = IDXW'($urandom);
		r.beat.x     = COORD'($urandom);
		r.beat.y     = COORD'($urandom);
		r.beat.z     = COORD'($urandom);
		r.beat.phase = ph;
		r.typed      = typed;
		r.want.px    = COORD'(px);
		r.want.py    = COORD'(py);
		r.want.pz    = COORD'(pz);
		r.want.vx    = VELW'(vx);
		r.want.vy    = VELW'(vy);
		r.want.vz    = VELW'(vz);
		plan.push_back(r);
	endfunction

	// offer one beat after a random idle gap, hold it until accepted
	task automatic send(input cmd_beat_t b, input logic typed, input res_beat_t want);
		while ($urandom_range(99) < send_idle) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.func        <= b.func;
		cmd_ch.point_index <= b.idx;
		cmd_ch.point_x     <= b.x;
		cmd_ch.point_y     <= b.y;
		cmd_ch.point_z     <= b.z;
		cmd_ch.phase       <= b.phase;
		row_typed          <= typed;
		row_want           <= want;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
	endtask

	// command side: update the point table, queue the result an evaluate owes
	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			accepted_beats <= accepted_beats + 1;
			if (cmd_ch.func == cbpe_pkg::FUNC_LOAD) begin
				if (cmd_ch.point_index < NPTS) begin
					pts[cmd_ch.point_index][0] = cmd_ch.point_x;
					pts[cmd_ch.point_index][1] = cmd_ch.point_y;
					pts[cmd_ch.point_index][2] = cmd_ch.point_z;
					loads_seen++;
				end else begin
					ignored_seen++;
				end
			end else begin
				evals_seen++;
				pending_results.push_back(row_typed ? row_want : bezier_eval(cmd_ch.phase));
			end
		end
	end

	// result side: compare against the oldest queued result
	always @(posedge clk) begin
		res_beat_t want;
		res_beat_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.px = res_ch.pos_x;
			got.py = res_ch.pos_y;
			got.pz = res_ch.pos_z;
			got.vx = res_ch.vel_x;
			got.vy = res_ch.vel_y;
			got.vz = res_ch.vel_z;
			results_seen++;
			if (got.vx == V_MAX || got.vx == V_MIN || got.vy == V_MAX || got.vy == V_MIN ||
					got.vz == V_MAX || got.vz == V_MIN)
				sat_seen++;
			if (pending_results.size() == 0) begin
				if (errors < 10)
					$display("unexpected result beat %0d: pos (%0d,%0d,%0d) vel (%0d,%0d,%0d)",
						results_seen, got.px, got.py, got.pz, got.vx, got.vy, got.vz);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz ||
						got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz) begin
					if (errors < 10) begin
						$display("result %0d mismatch: expected pos (%0d,%0d,%0d) vel (%0d,%0d,%0d)",
							results_seen, want.px, want.py, want.pz, want.vx, want.vy, want.vz);
						$display("                    got      pos (%0d,%0d,%0d) vel (%0d,%0d,%0d)",
							got.px, got.py, got.pz, got.vx, got.vy, got.vz);
					end
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold while the sender keeps going
	initial begin
		int   hold_left;
		logic held;
		hold_left = 0;
		held      = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && accepted_beats >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// stimulus and end of run
	initial begin
		int        counted;
		int        waited;
		int        mix;
		int        idle_send[4];
		int        idle_recv[4];
		cmd_beat_t b;
		res_beat_t none;

		idle_send = '{0, 58, 0, 31};
		idle_recv = '{0, 0, 58, 31};
		none      = '0;
		errors         = 0;
		loads_seen     = 0;
		ignored_seen   = 0;
		evals_seen     = 0;
		results_seen   = 0;
		sat_seen       = 0;
		send_idle      = 0;
		accepted_beats <= 0;
		recv_stall     <= 0;

		arst_n             <= 1'b0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.func        <= cbpe_pkg::FUNC_LOAD;
		cmd_ch.point_index <= '0;
		cmd_ch.point_x     <= '0;
		cmd_ch.point_y     <= '0;
		cmd_ch.point_z     <= '0;
		cmd_ch.phase       <= '0;
		row_typed          <= 1'b0;
		row_want           <= '0;

		// segment 0 with x and y at the coordinate extremes
		put_load(0, C_MIN, C_MAX, 0);
		put_load(1, C_MAX, C_MIN, 256);
		put_load(2, C_MIN, C_MAX, -1);
		put_load(3, C_MAX, C_MIN, C_MAX);
		// t = 0 gives the first point and a velocity saturated in x and y, also after phase wrap
		put_eval(32'h0000_0000, 1'b1, C_MIN, C_MAX, 0, V_MAX, V_MIN, 768);
		put_eval(32'h0008_0000, 1'b1, C_MIN, C_MAX, 0, V_MAX, V_MIN, 768);
		put_eval(32'hFFF8_0000, 1'b1, C_MIN, C_MAX, 0, V_MAX, V_MIN, 768);
		put_eval(32'h0000_FFFF, 1'b0, 0, 0, 0, 0, 0, 0);
		put_eval(32'h0000_8000, 1'b0, 0, 0, 0, 0, 0, 0);
		put_eval(32'hFFF8_FFFF, 1'b0, 0, 0, 0, 0, 0, 0);
		// out-of-range loads leave the table alone
		put_load(NPTS, 1, 2, 3);
		put_load(31, C_MAX, C_MAX, C_MAX);
		put_eval(32'h0000_0000, 1'b1, C_MIN, C_MAX, 0, V_MAX, V_MIN, 768);
		// segment 1 collapsed to one point: fixed position, zero velocity
		put_load(4, C_MAX, C_MIN, C_MAX);
		put_load(5, C_MAX, C_MIN, C_MAX);
		put_load(6, C_MAX, C_MIN, C_MAX);
		put_eval(32'h0001_0000, 1'b1, C_MAX, C_MIN, C_MAX, 0, 0, 0);
		put_eval(32'h0001_FFFF, 1'b1, C_MAX, C_MIN, C_MAX, 0, 0, 0);
		put_eval(32'h0009_4000, 1'b1, C_MAX, C_MIN, C_MAX, 0, 0, 0);

		// reset
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i])
			send(plan[i].beat, plan[i].typed, plan[i].want);

		// fill the whole table before any random evaluate
		for (int i = 0; i < NPTS; i++) begin
			b       = rand_cmd();
			b.func  = cbpe_pkg::FUNC_LOAD;
			b.idx   = IDXW'(i);
			send(b, 1'b0, none);
		end

		// random mix under each idle pattern
		for (mix = 0; mix < 4; mix++) begin
			send_idle  = idle_send[mix];
			recv_stall <= idle_recv[mix];
			counted    = 0;
			while (counted < ITEMS_PER_MIX) begin
				b = rand_cmd();
				send(b, 1'b0, none);
				if (!(b.func == cbpe_pkg::FUNC_LOAD && b.idx >= NPTS))
					counted++;
			end
		end
		cmd_ch.valid <= 1'b0;

		// drain, then watch for stray beats
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4 * LATENCY) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d results never arrived", pending_results.size());
			errors += pending_results.size();
		end

		$display("ran %0d point loads (%0d out-of-range dropped) and %0d evaluations, %0d results",
			loads_seen, ignored_seen, evals_seen, results_seen);
		$display("%0d results hit velocity saturation; idle mixes 0/58/58/31 pct, one %0d-cycle hold",
			sat_seen, HOLD_CYCLES);
		if (errors == 0) begin
			$display("[cubic_bezier_path_evaluator_top] OK");
		end else begin
			$display("%0d failures", errors);
			$display("[cubic_bezier_path_evaluator_top] ERROR");
		end
		$finish;
	end

endmodule
